[rtl/core/sktbl_pkg.sv]
// Shared types and codes for the sorted key/value leaf table.
`default_nettype none
package sktbl_pkg;

    localparam logic [3:0] MODE_LOOKUP      = 4'd0;
    localparam logic [3:0] MODE_INSERT      = 4'd1;
    localparam logic [3:0] MODE_REMOVE      = 4'd2;
    localparam logic [3:0] MODE_LOWER_BOUND = 4'd3;
    localparam logic [3:0] MODE_READ_AT     = 4'd4;
    localparam logic [3:0] MODE_TAKE_FIRST  = 4'd5;
    localparam logic [3:0] MODE_TAKE_LAST   = 4'd6;
    localparam logic [3:0] MODE_PUSH_FIRST  = 4'd7;
    localparam logic [3:0] MODE_PUSH_LAST   = 4'd8;
    localparam logic [3:0] MODE_SPLIT       = 4'd9;
    localparam logic [3:0] MODE_DRAIN       = 4'd10;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_DUPLICATE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;
    localparam logic [2:0] STAT_RANGE     = 3'd5;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] key;
        logic [31:0]        value;
        logic [5:0]         index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [31:0]        out_value;
        logic [6:0]         position;
        logic [6:0]         entry_total;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_EXEC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load_op;
        logic compare;
        logic encode;
        logic exec_single;
        logic emit_start;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic multi;
        logic emit_last;
    } stat_t;

endpackage
`default_nettype wire

[rtl/core/sorted_key_value_leaf_table_top.sv]
// Top level of the sorted key/value leaf table.
//
// Usage: one operation per transfer on the req channel (mode, key, value,
// index); results leave on the rsp channel, each transfer one result, the
// final one of an operation marked by last.
// Each operation walks a fixed sequence: accept, compare the key against all
// live entries at once, priority-encode the lower bound, execute. A single-
// result operation shows its result in the output register in the
// cycle after execute.
// Split and drain then emit one entry per cycle while the output register
// is free; the emit rate is set by the single read port of the entry row.
// The output register holds a finished result while the next operation is
// accepted and processed; when the receiver stalls, execute and emit steps
// hold until the output register frees up, then proceed.
// Reset clears the entry count and the output valid flag; the entry storage
// itself is not cleared and is read only below the count.
// Insert and remove shift the entry row by one position in the execute step.
`default_nettype none
module sorted_key_value_leaf_table_top
    import sktbl_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire in_item_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output out_item_t     rsp
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns the operation phases
    sktbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: entries, compare, shift and the output register
    sktbl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    // busy right after a request transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous operation in flight");

    // entry count never exceeds capacity
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_total <= 7'(CAPACITY)))
        else $error("entry total beyond capacity");

    // only emit streams have non-final results, and those are ok
    a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> (rsp.status == STAT_OK))
        else $error("non-final result with error status");
`endif

endmodule
`default_nettype wire

[rtl/core/sktbl_ctrl.sv]
// Sequencer for the leaf table: steps each operation through compare, encode, execute, emit.
`default_nettype none
module sktbl_ctrl
    import sktbl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_ENC;
            end
            S_ENC:
            begin
                cmd.encode = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.multi)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (stat.out_free)
                begin
                    cmd.exec_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                // advance one entry per free output slot
                if (stat.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/sktbl_dp.sv]
// Datapath of the leaf table: entry registers, parallel compare, encoder, shifter, output register.
`default_nettype none
module sktbl_dp
    import sktbl_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t req,
    output out_item_t     rsp,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    input  wire cmd_t     cmd,
    output stat_t         stat
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [31:0] key_reg [CAPACITY];
    logic [31:0]        val_reg [CAPACITY];
    logic signed [31:0] key_next [CAPACITY];
    logic [31:0]        val_next [CAPACITY];

    in_item_t        op_reg;
    logic [CAPACITY-1:0] ge_reg;
    logic [CAPACITY-1:0] ge_vec;
    logic [CW-1:0]   pos_reg;
    logic [CW-1:0]   pos_enc;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   emit_idx_reg;
    logic [CW-1:0]   emit_end_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;

    logic [IW-1:0]      rd_addr;
    logic signed [31:0] rd_key;
    logic [31:0]        rd_val;

    out_item_t       res;
    logic [CW-1:0]   count_new;
    logic [CW-1:0]   n_emit;
    logic            ins_en;
    logic            rem_en;
    logic [CW-1:0]   ins_pos;
    logic [CW-1:0]   rem_pos;
    logic            hit;
    logic            found;
    logic            full;
    logic            empty;
    logic            emit_last;
    out_item_t       emit_item;

    // compare every live entry against the search key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ge_vec[i] = (CW'(i) < count_reg) && ($signed(key_reg[i]) >= $signed(op_reg.key));
        end
    end

    // first set flag, or the count if none
    always_comb
    begin
        pos_enc = count_reg;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (ge_reg[i])
            begin
                pos_enc = CW'(i);
            end
        end
    end

    always_comb
    begin
        if (cmd.emit_step)
        begin
            rd_addr = IW'(emit_idx_reg);
        end
        else if (op_reg.mode == MODE_READ_AT)
        begin
            rd_addr = IW'(op_reg.index);
        end
        else if (op_reg.mode == MODE_TAKE_FIRST)
        begin
            rd_addr = '0;
        end
        else if (op_reg.mode == MODE_TAKE_LAST)
        begin
            rd_addr = IW'(count_reg - CW'(1));
        end
        else
        begin
            rd_addr = IW'(pos_reg);
        end
    end

    always_comb
    begin
        rd_key = '0;
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_addr == IW'(i))
            begin
                rd_key = key_reg[i];
                rd_val = val_reg[i];
            end
        end
    end

    assign hit    = pos_reg < count_reg;
    assign found  = hit && (rd_key == op_reg.key);
    assign full   = count_reg == CAP_C;
    assign empty  = count_reg == '0;
    assign n_emit = (op_reg.mode == MODE_SPLIT) ? (count_reg >> 1) : count_reg;

    always_comb
    begin
        res           = '0;
        res.status    = STAT_OK;
        res.last      = 1'b1;
        res.position  = 7'(pos_reg);
        count_new     = count_reg;
        ins_en        = 1'b0;
        rem_en        = 1'b0;
        ins_pos       = pos_reg;
        rem_pos       = pos_reg;
        case (op_reg.mode)
            MODE_LOOKUP:
            begin
                if (found)
                begin
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            MODE_INSERT:
            begin
                if (found)
                begin
                    res.status    = STAT_DUPLICATE;
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                end
                else if (full)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    ins_en        = 1'b1;
                    res.out_key   = op_reg.key;
                    res.out_value = op_reg.value;
                    count_new     = count_reg + CW'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (found)
                begin
                    rem_en        = 1'b1;
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                    count_new     = count_reg - CW'(1);
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            MODE_LOWER_BOUND:
            begin
                if (hit)
                begin
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                end
            end
            MODE_READ_AT:
            begin
                res.position = {1'b0, op_reg.index};
                if ({1'b0, op_reg.index} < 7'(count_reg))
                begin
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            MODE_TAKE_FIRST, MODE_TAKE_LAST:
            begin
                res.position = '0;
                if (empty)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    if (op_reg.mode == MODE_TAKE_LAST)
                    begin
                        res.position = 7'(count_reg - CW'(1));
                    end
                    else
                    begin
                        rem_en  = 1'b1;
                        rem_pos = '0;
                    end
                    res.out_key   = rd_key;
                    res.out_value = rd_val;
                    count_new     = count_reg - CW'(1);
                end
            end
            MODE_PUSH_FIRST, MODE_PUSH_LAST:
            begin
                res.position = '0;
                if (full)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    ins_en  = 1'b1;
                    ins_pos = (op_reg.mode == MODE_PUSH_LAST) ? count_reg : '0;
                    res.position  = 7'(ins_pos);
                    res.out_key   = op_reg.key;
                    res.out_value = op_reg.value;
                    count_new     = count_reg + CW'(1);
                end
            end
            MODE_SPLIT, MODE_DRAIN:
            begin
                res.position = '0;
                res.status   = STAT_EMPTY;
            end
            default:
            begin
                res.position = '0;
            end
        endcase
        res.entry_total = 7'(count_new);
    end

    assign emit_last = (emit_idx_reg + CW'(1)) == emit_end_reg;

    always_comb
    begin
        emit_item             = '0;
        emit_item.status      = STAT_OK;
        emit_item.out_key     = rd_key;
        emit_item.out_value   = rd_val;
        emit_item.position    = 7'(emit_idx_reg);
        emit_item.entry_total = 7'(count_reg);
        emit_item.last        = emit_last;
    end

    // open a gap for insert, close one for remove
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_next[i] = key_reg[i];
            val_next[i] = val_reg[i];
        end
        if (ins_en)
        begin
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (CW'(i) > ins_pos)
                begin
                    key_next[i] = key_reg[i-1];
                    val_next[i] = val_reg[i-1];
                end
            end
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CW'(i) == ins_pos)
                begin
                    key_next[i] = op_reg.key;
                    val_next[i] = op_reg.value;
                end
            end
        end
        else if (rem_en)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (CW'(i) >= rem_pos)
                begin
                    key_next[i] = key_reg[i+1];
                    val_next[i] = val_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_single)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_reg[i] <= key_next[i];
                val_reg[i] <= val_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_reg <= req;
        end
        if (cmd.compare)
        begin
            ge_reg <= ge_vec;
        end
        if (cmd.encode)
        begin
            pos_reg <= pos_enc;
        end
        if (cmd.emit_start)
        begin
            emit_idx_reg <= count_reg - n_emit;
            emit_end_reg <= count_reg;
        end
        else if (cmd.emit_step)
        begin
            emit_idx_reg <= emit_idx_reg + CW'(1);
        end
        if (cmd.exec_single)
        begin
            out_reg <= res;
        end
        else if (cmd.emit_step)
        begin
            out_reg <= emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec_single)
            begin
                count_reg <= count_new;
            end
            else if (cmd.emit_start)
            begin
                count_reg <= count_reg - n_emit;
            end
            if (cmd.exec_single || cmd.emit_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free  = !out_valid_reg || rsp_ready;
    assign stat.multi     = ((op_reg.mode == MODE_SPLIT) || (op_reg.mode == MODE_DRAIN))
                            && (n_emit != '0);
    assign stat.emit_last = emit_last;

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire
